// ----- hdl/atc_pkg.sv -----
// Shared types, codes and constants of the assembler token classifier.
// No dependencies; used by every module of the block.
`default_nettype none
package atc_pkg;

	// Default accumulator width and depth of the queue between front and back.
	localparam int ACC_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	// Widths fixed by the item fields.
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 8;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int VALUE_W = 16;

	// Character codes that steer the classification.
	localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PCT  = 8'h25;
	localparam logic [CHAR_W-1:0] CH_BANG = 8'h21;
	localparam logic [CHAR_W-1:0] CH_LC_B = 8'h62;
	localparam logic [CHAR_W-1:0] CH_LC_D = 8'h64;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

	// Range limits of registers and immediates.
	localparam int REG_MAX = 15;
	localparam int IMM_MAX = 255;

	// Token class as tracked character by character.
	typedef enum logic [2:0] {
		CLS_LABEL    = 3'd0,
		CLS_REG      = 3'd1,
		CLS_IMM_PEND = 3'd2,
		CLS_IMM_BIN  = 3'd3,
		CLS_IMM_DEC  = 3'd4,
		CLS_IMM_BAD  = 3'd5,
		CLS_ZERO     = 3'd6,
		CLS_MNEM     = 3'd7
	} atc_cls_t;

	// Result kind.
	typedef enum logic [KIND_W-1:0] {
		KIND_LABEL = 2'd0,
		KIND_REG   = 2'd1,
		KIND_NUM   = 2'd2,
		KIND_MNEM  = 2'd3
	} atc_kind_t;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_LABEL = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_REG   = 3'd2;
	localparam logic [STAT_W-1:0] ST_REG_RANGE = 3'd3;
	localparam logic [STAT_W-1:0] ST_IMM_RANGE = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_IMM   = 3'd5;

	// Everything of a finished token but its accumulator.
	typedef struct packed {
		atc_cls_t          cls;
		logic              single;
		logic              saw_digit;
		logic              digit_error;
		logic [POS_W-1:0]  line;
		logic [POS_W-1:0]  col;
	} atc_tok_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} atc_qstat_t;

endpackage
`default_nettype wire

// ----- hdl/assembler_token_classifier_top.sv -----
// Top level of the assembler token classifier: front, queue and back joined to stream ports.
// Depends on atc_pkg, atc_front, atc_queue and atc_back.
//
// Use: the characters of one token arrive on the slave stream, one character per beat,
// with tlast high on the token's final character; the line and column beside the first
// character are kept for the result. Each token yields exactly one result beat on the
// master stream, carrying kind, status, value and the token's line and column.
// Throughput is one character per clock cycle while the queue has room, without gaps
// between tokens. The front updates the class and the accumulator per character (one
// multiply-by-ten-and-add for a decimal digit, one shift for a binary digit), and that
// single step is the only work on the character path. The clock edge that accepts the
// beat with tlast writes the finished token into the queue; when it heads the queue and
// the output register is free, a later edge loads its classified result and m_tvalid rises.
// When the receiver stalls, the result is held in the output register and further
// finished tokens collect in the queue (FIFO_DEPTH entries); s_tready falls only once
// the queue is full, and characters are then held off until the back drains an entry.
// After reset the queue and the output register are empty and the front expects the
// first character of a new token; no initialisation is needed.
`default_nettype none
module assembler_token_classifier_top #(
	parameter int ACC_WIDTH  = atc_pkg::ACC_WIDTH_DEF,
	parameter int FIFO_DEPTH = atc_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // char_code[7:0], src_line[15:8], src_col[23:16]
	input  wire logic        s_tlast,  // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // token_kind[1:0], status[4:2], value[20:5],
	                                   // line_out[28:21], col_out[36:29], zeros[39:37]
);

	localparam int TOK_W  = $bits(atc_pkg::atc_tok_t);
	localparam int DATA_W = TOK_W + ACC_WIDTH;

	logic                              s_accept;
	logic                              push;
	atc_pkg::atc_tok_t                 tok_in, tok_out;
	logic [ACC_WIDTH-1:0]              acc_in, acc_out;
	logic [DATA_W-1:0]                 q_rdata;
	atc_pkg::atc_qstat_t               qstat;
	logic                              pop;
	atc_pkg::atc_kind_t                kind;
	logic [atc_pkg::STAT_W-1:0]        status;
	logic [atc_pkg::VALUE_W-1:0]       value;
	logic [atc_pkg::POS_W-1:0]         line_out, col_out;

	// A beat is taken whenever there is room for a finished token in the queue.
	assign s_tready = !qstat.full;
	assign s_accept = s_tvalid && s_tready;

	atc_front #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.char_code  (s_tdata[7:0]),
		.last_char  (s_tlast),
		.src_line   (s_tdata[15:8]),
		.src_col    (s_tdata[23:16]),
		.push       (push),
		.tok        (tok_in),
		.tok_acc    (acc_in)
	);

	atc_queue #(
		.DATA_W(DATA_W),
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({tok_in, acc_in}),
		.pop   (pop),
		.rdata (q_rdata),
		.stat  (qstat)
	);

	assign tok_out = q_rdata[DATA_W-1:ACC_WIDTH];
	assign acc_out = q_rdata[ACC_WIDTH-1:0];

	atc_back #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.tok      (tok_out),
		.tok_acc  (acc_out),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.kind     (kind),
		.status   (status),
		.value    (value),
		.line_out (line_out),
		.col_out  (col_out)
	);

	assign m_tdata = {3'b000, col_out, line_out, value, status, kind};

	// The queue can never be full and empty at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty together");

	// A token closed by an accepted beat is waiting in the queue in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tlast) |=> !qstat.empty)
		else $error("finished token did not reach the queue");

	// Every error result carries the label kind code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status != atc_pkg::ST_OK) |-> (kind == atc_pkg::KIND_LABEL))
		else $error("error result with non-zero kind");

	// A valid register result never exceeds the register range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status == atc_pkg::ST_OK && kind == atc_pkg::KIND_REG)
		|-> (value <= atc_pkg::VALUE_W'(atc_pkg::REG_MAX)))
		else $error("register index out of range reported as ok");

endmodule
`default_nettype wire

// ----- hdl/atc_front.sv -----
// Front of the classifier: takes one character per beat and tracks class and accumulator.
// Depends on atc_pkg; pushes each finished token into atc_queue.
`default_nettype none
module atc_front #(
	parameter int ACC_WIDTH = atc_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [atc_pkg::CHAR_W-1:0]    char_code,
	input  wire logic                          last_char,
	input  wire logic [atc_pkg::POS_W-1:0]     src_line,
	input  wire logic [atc_pkg::POS_W-1:0]     src_col,
	output logic                               push,
	output atc_pkg::atc_tok_t                  tok,
	output logic [ACC_WIDTH-1:0]               tok_acc
);

	logic [1:0]               pos_q;
	atc_pkg::atc_cls_t        cls_q, cls_n;
	logic [ACC_WIDTH-1:0]     acc_q, acc_n;
	logic                     err_q, err_n;
	logic                     saw_q, saw_n;
	logic [atc_pkg::POS_W-1:0] line_q, line_n, col_q, col_n;
	logic                     first;
	logic                     is_dec, is_bin;

	assign first  = (pos_q == 2'd0);
	assign is_dec = (char_code >= atc_pkg::CH_ZERO) && (char_code <= atc_pkg::CH_NINE);
	assign is_bin = (char_code == atc_pkg::CH_ZERO) || (char_code == atc_pkg::CH_ONE);

	always_comb begin
		cls_n  = cls_q;
		acc_n  = acc_q;
		err_n  = err_q;
		saw_n  = saw_q;
		line_n = line_q;
		col_n  = col_q;
		if (first) begin
			line_n = src_line;
			col_n  = src_col;
			acc_n  = '0;
			err_n  = 1'b0;
			saw_n  = 1'b0;
			if (char_code == atc_pkg::CH_HASH) begin
				cls_n = atc_pkg::CLS_LABEL;
			end else if (char_code == atc_pkg::CH_PCT) begin
				cls_n = atc_pkg::CLS_REG;
			end else if (char_code == atc_pkg::CH_BANG) begin
				cls_n = atc_pkg::CLS_IMM_PEND;
			end else if (char_code == atc_pkg::CH_ZERO) begin
				cls_n = atc_pkg::CLS_ZERO;
			end else begin
				cls_n = atc_pkg::CLS_MNEM;
			end
		end else begin
			unique case (cls_q) inside
				atc_pkg::CLS_REG, atc_pkg::CLS_IMM_DEC: begin
					if (is_dec) begin
						acc_n = (acc_q << 3) + (acc_q << 1) + ACC_WIDTH'(char_code[3:0]);
						saw_n = 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end
				atc_pkg::CLS_IMM_BIN: begin
					if (is_bin) begin
						acc_n = {acc_q[ACC_WIDTH-2:0], char_code[0]};
						saw_n = 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end
				atc_pkg::CLS_IMM_PEND: begin
					if (char_code == atc_pkg::CH_LC_B) begin
						cls_n = atc_pkg::CLS_IMM_BIN;
					end else if (char_code == atc_pkg::CH_LC_D) begin
						cls_n = atc_pkg::CLS_IMM_DEC;
					end else begin
						cls_n = atc_pkg::CLS_IMM_BAD;
					end
				end
				atc_pkg::CLS_ZERO: begin
					cls_n = atc_pkg::CLS_MNEM;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 2'd0;
			cls_q  <= atc_pkg::CLS_LABEL;
			acc_q  <= '0;
			err_q  <= 1'b0;
			saw_q  <= 1'b0;
			line_q <= '0;
			col_q  <= '0;
		end else if (accept) begin
			cls_q  <= cls_n;
			acc_q  <= acc_n;
			err_q  <= err_n;
			saw_q  <= saw_n;
			line_q <= line_n;
			col_q  <= col_n;
			if (last_char) begin
				pos_q <= 2'd0;
			end else if (pos_q != 2'd2) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	// The finished token carries the state as updated by its last character.
	assign push             = accept && last_char;
	assign tok.cls          = cls_n;
	assign tok.single       = first;
	assign tok.saw_digit    = saw_n;
	assign tok.digit_error  = err_n;
	assign tok.line         = line_n;
	assign tok.col          = col_n;
	assign tok_acc          = acc_n;

endmodule
`default_nettype wire

// ----- hdl/atc_queue.sv -----
// Short first-word-fall-through queue between the front and the back.
// Depends on atc_pkg for the status struct.
`default_nettype none
module atc_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = atc_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rdata,
	output atc_pkg::atc_qstat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] regs_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = regs_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			regs_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/atc_back.sv -----
// Back of the classifier: turns a finished token into kind, status and value.
// Depends on atc_pkg; pops atc_queue and holds the result in an output register.
`default_nettype none
module atc_back #(
	parameter int ACC_WIDTH = atc_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire atc_pkg::atc_qstat_t         qstat,
	input  wire atc_pkg::atc_tok_t           tok,
	input  wire logic [ACC_WIDTH-1:0]        tok_acc,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output atc_pkg::atc_kind_t               kind,
	output logic [atc_pkg::STAT_W-1:0]       status,
	output logic [atc_pkg::VALUE_W-1:0]      value,
	output logic [atc_pkg::POS_W-1:0]        line_out,
	output logic [atc_pkg::POS_W-1:0]        col_out
);

	atc_pkg::atc_kind_t             kind_c;
	logic [atc_pkg::STAT_W-1:0]     stat_c;
	logic [atc_pkg::VALUE_W-1:0]    value_c;
	logic                           bad_digits;
	logic [atc_pkg::VALUE_W-1:0]    acc_val;

	assign bad_digits = !tok.saw_digit || tok.digit_error;
	assign acc_val    = atc_pkg::VALUE_W'(tok_acc);

	always_comb begin
		kind_c  = atc_pkg::KIND_LABEL;
		stat_c  = atc_pkg::ST_OK;
		value_c = '0;
		unique case (tok.cls) inside
			atc_pkg::CLS_LABEL: begin
				if (tok.single) begin
					stat_c = atc_pkg::ST_BAD_LABEL;
				end
			end
			atc_pkg::CLS_REG: begin
				if (bad_digits) begin
					stat_c = atc_pkg::ST_BAD_REG;
				end else if (tok_acc > ACC_WIDTH'(atc_pkg::REG_MAX)) begin
					stat_c  = atc_pkg::ST_REG_RANGE;
					value_c = acc_val;
				end else begin
					kind_c  = atc_pkg::KIND_REG;
					value_c = acc_val;
				end
			end
			atc_pkg::CLS_IMM_BIN, atc_pkg::CLS_IMM_DEC: begin
				if (bad_digits) begin
					stat_c = atc_pkg::ST_BAD_IMM;
				end else if (tok_acc > ACC_WIDTH'(atc_pkg::IMM_MAX)) begin
					stat_c  = atc_pkg::ST_IMM_RANGE;
					value_c = acc_val;
				end else begin
					kind_c  = atc_pkg::KIND_NUM;
					value_c = acc_val;
				end
			end
			atc_pkg::CLS_IMM_PEND, atc_pkg::CLS_IMM_BAD: begin
				stat_c = atc_pkg::ST_BAD_IMM;
			end
			atc_pkg::CLS_ZERO: begin
				kind_c = atc_pkg::KIND_NUM;
			end
			default: begin
				kind_c = atc_pkg::KIND_MNEM;
			end
		endcase
	end

	// Load a new result whenever the queue holds a token and the output register is empty or being drained.
	assign pop = !qstat.empty && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind     <= kind_c;
			status   <= stat_c;
			value    <= value_c;
			line_out <= tok.line;
			col_out  <= tok.col;
		end
	end

endmodule
`default_nettype wire
